// ===== design/per_sensor_vehicle_count_accumulator_assert.svh =====
// Assertion macros for the per-sensor vehicle count accumulator.
`ifndef PER_SENSOR_VEHICLE_COUNT_ACCUMULATOR_ASSERT_SVH
`define PER_SENSOR_VEHICLE_COUNT_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PVCA_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("pvca: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PVCA_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("pvca: next-cycle check failed");

`endif

// ===== design/pvca_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvca_pkg
// Shared constants and types of the per-sensor vehicle count accumulator.
// ----------------------------------------------------------------------------
package pvca_pkg;

    localparam int ID_REGS   = 6;
    localparam int DEF_SLOTS = 6;
    localparam int COUNT_W   = 16;
    localparam int ID_W      = 16;
    localparam int TYPE_W    = 8;
    localparam int FUNC_W    = 1;
    localparam int IN_DATA_W = 56;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_CODE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_B = 3'd7;

    localparam logic [FUNC_W-1:0]  FUNC_READ = 1'b1;
    localparam logic [COUNT_W-1:0] WRAP_BASE = 16'hffff;

    typedef struct packed {
        logic [ID_REGS-1:0][ID_W-1:0] slot_id;
        logic [TYPE_W-1:0]            code_a;
        logic [TYPE_W-1:0]            code_b;
    } cfg_t;

    typedef struct packed {
        logic load_in;
        logic exec;
    } cmd_t;

    typedef struct packed {
        logic is_read;
        logic out_busy;
    } status_t;

endpackage

// ===== design/pvca_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvca_cfg
// APB register file: six slot IDs and two car-leaving packet type codes.
// ----------------------------------------------------------------------------
module pvca_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pvca_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [pvca_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [pvca_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready,
    output pvca_pkg::cfg_t                     cfg
);

    pvca_pkg::cfg_t                   cfg_reg;
    logic [pvca_pkg::CFG_IDX_W-1:0]   idx;
    logic                             wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[pvca_pkg::CFG_ADDR_W-1:2];
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            if (idx < pvca_pkg::CFG_IDX_W'(pvca_pkg::ID_REGS))
            begin
                cfg_reg.slot_id[idx] <= pwdata[pvca_pkg::ID_W-1:0];
            end
            else if (idx == pvca_pkg::REG_CODE_A)
            begin
                cfg_reg.code_a <= pwdata[pvca_pkg::TYPE_W-1:0];
            end
            else if (idx == pvca_pkg::REG_CODE_B)
            begin
                cfg_reg.code_b <= pwdata[pvca_pkg::TYPE_W-1:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (idx < pvca_pkg::CFG_IDX_W'(pvca_pkg::ID_REGS))
        begin
            prdata = pvca_pkg::CFG_DATA_W'(cfg_reg.slot_id[idx]);
        end
        else if (idx == pvca_pkg::REG_CODE_A)
        begin
            prdata = pvca_pkg::CFG_DATA_W'(cfg_reg.code_a);
        end
        else if (idx == pvca_pkg::REG_CODE_B)
        begin
            prdata = pvca_pkg::CFG_DATA_W'(cfg_reg.code_b);
        end
    end

endmodule

// ===== design/pvca_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvca_ctrl
// Sequencer: capture one item, execute it, stall a read while the result slot is full.
// ----------------------------------------------------------------------------
module pvca_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pvca_pkg::status_t status,
    output pvca_pkg::cmd_t    cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cmd.load_in = 1'b0;
        cmd.exec    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // hold a read until the output register can take its result
                if (!status.is_read || !status.out_busy)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/pvca_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvca_dp
// Slot table datapath: input capture, per-slot count update, read and clear,
// output register.
// ----------------------------------------------------------------------------
module pvca_dp #(
    parameter int SLOTS = pvca_pkg::DEF_SLOTS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pvca_pkg::cfg_t                     cfg,
    input  pvca_pkg::cmd_t                     cmd,
    output pvca_pkg::status_t                  status,
    input  logic [pvca_pkg::FUNC_W-1:0]        in_func,
    input  logic [pvca_pkg::IN_DATA_W-1:0]     in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [pvca_pkg::OUT_DATA_W-1:0]    out_data
);

    localparam int CW = pvca_pkg::COUNT_W;

    logic [pvca_pkg::FUNC_W-1:0] func_reg;
    logic [pvca_pkg::TYPE_W-1:0] type_reg;
    logic [pvca_pkg::ID_W-1:0]   addr_reg;
    logic [CW-1:0]               cnt_reg;
    logic [pvca_pkg::ID_W-1:0]   qid_reg;

    logic [CW-1:0] last_reg [SLOTS];
    logic [CW-1:0] vol_reg  [SLOTS];

    logic [SLOTS-1:0] upd_hit;
    logic [SLOTS-1:0] rd_hit;
    logic [CW-1:0]    add_val [SLOTS];
    logic [SLOTS-1:0] changes;
    logic             leave;
    logic             is_read;
    logic [CW-1:0]    rd_vol;

    logic          out_valid_reg;
    logic [CW-1:0] out_data_reg;

    assign is_read   = (func_reg == pvca_pkg::FUNC_READ);
    assign leave     = (type_reg == cfg.code_a) || (type_reg == cfg.code_b);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign status.is_read  = is_read;
    assign status.out_busy = out_valid_reg & ~out_ready;

    // capture the transfer; payload needs no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_reg <= in_func;
            type_reg <= in_data[7:0];
            addr_reg <= in_data[23:8];
            cnt_reg  <= in_data[39:24];
            qid_reg  <= in_data[55:40];
        end
    end

    for (genvar s = 0; s < SLOTS; s++)
    begin : g_slot
        assign upd_hit[s] = (cfg.slot_id[s] == addr_reg);
        assign rd_hit[s]  = (cfg.slot_id[s] == qid_reg);

        always_comb
        begin
            changes[s] = 1'b1;
            if (last_reg[s] == '0)
            begin
                add_val[s] = CW'(1);
            end
            else if (cnt_reg > last_reg[s])
            begin
                add_val[s] = cnt_reg - last_reg[s];
            end
            else if (cnt_reg < last_reg[s])
            begin
                add_val[s] = pvca_pkg::WRAP_BASE - last_reg[s] + cnt_reg;
            end
            else
            begin
                add_val[s]  = '0;
                changes[s] = 1'b0;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                last_reg[s] <= '0;
                vol_reg[s]  <= '0;
            end
            else if (cmd.exec)
            begin
                if (is_read)
                begin
                    if (rd_hit[s])
                    begin
                        vol_reg[s] <= '0;
                    end
                end
                else if (leave && upd_hit[s] && changes[s])
                begin
                    vol_reg[s]  <= vol_reg[s] + add_val[s];
                    last_reg[s] <= cnt_reg;
                end
            end
        end
    end

    // highest-numbered matching slot wins
    always_comb
    begin
        rd_vol = '0;
        for (int s = 0; s < SLOTS; s++)
        begin
            if (rd_hit[s])
            begin
                rd_vol = vol_reg[s];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.exec && is_read)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && is_read)
        begin
            out_data_reg <= rd_vol;
        end
    end

endmodule

// ===== design/per_sensor_vehicle_count_accumulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_sensor_vehicle_count_accumulator
// Per-slot car volume accumulation from sensor counts, with read and clear.
// ----------------------------------------------------------------------------
// Channel    Direction  Transfer when            Contents
// s_axis     in         s_axis_tvalid & tready   update or read item
// m_axis     out        m_axis_tvalid & tready   volume of a read item
// apb        in         psel & penable & pwrite  slot IDs, leave codes
//
// An item is captured, then handled in the controller's execute
// step, where all slots compare and update in parallel.
// A read whose result finds the output register still full waits in the
// execute step until that result is transferred.
// Reset clears the slot counts, volumes and configuration at once.
// ----------------------------------------------------------------------------
`include "per_sensor_vehicle_count_accumulator_assert.svh"

module per_sensor_vehicle_count_accumulator #(
    parameter int SLOTS = pvca_pkg::DEF_SLOTS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // s_axis_tdata: packet_type[7:0], sensor_addr[23:8], count_value[39:24],
    //               query_id[55:40]
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [pvca_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // s_axis_tuser: func[0]
    input  logic [pvca_pkg::FUNC_W-1:0]        s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // m_axis_tdata: volume[15:0]
    output logic [pvca_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pvca_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [pvca_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [pvca_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready
);

    pvca_pkg::cfg_t    cfg;
    pvca_pkg::cmd_t    cmd;
    pvca_pkg::status_t status;

    pvca_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pvca_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pvca_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .status    (status),
        .in_func   (s_axis_tuser),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

    // a captured item blocks the input for its execute step
    `PVCA_ASSERT_NXT(a_busy_after_accept, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // execute frees the input in the next cycle unless a pending result blocks it
    `PVCA_ASSERT_NXT(a_exec_done, clk, rst_n, !s_axis_tready && !(m_axis_tvalid && !m_axis_tready), s_axis_tready)
    // a new result is only produced from the execute step
    `PVCA_ASSERT_IMP(a_result_from_exec, clk, rst_n, $rose(m_axis_tvalid), $past(!s_axis_tready))

endmodule

// ===== verif/vehicle_count_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vehicle_count_checker
// Watches the item, result and register channels of the accumulator, keeps
// its own slot table, and compares every volume against the predicted one.
// ----------------------------------------------------------------------------
module vehicle_count_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic [pvca_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic [pvca_pkg::FUNC_W-1:0]        s_axis_tuser,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [pvca_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pvca_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [pvca_pkg::CFG_DATA_W-1:0]    pwdata,
    input  logic                               pready,
    output int                                 pending,
    output int                                 errors
);

    typedef struct packed {
        logic [pvca_pkg::ID_W-1:0]    query_id;
        logic [pvca_pkg::COUNT_W-1:0] count_value;
        logic [pvca_pkg::ID_W-1:0]    sensor_addr;
        logic [pvca_pkg::TYPE_W-1:0]  packet_type;
    } sensor_item_t;

    logic [pvca_pkg::ID_W-1:0]       sensor_id [pvca_pkg::ID_REGS];
    logic [pvca_pkg::TYPE_W-1:0]     leave_a;
    logic [pvca_pkg::TYPE_W-1:0]     leave_b;
    logic [pvca_pkg::COUNT_W-1:0]    last_seen [pvca_pkg::ID_REGS];
    logic [pvca_pkg::COUNT_W-1:0]    volume_acc [pvca_pkg::ID_REGS];
    logic [pvca_pkg::OUT_DATA_W-1:0] volume_expected [$];

    // Volume growth for one slot given the stored and the new running count.
    function automatic logic [pvca_pkg::COUNT_W-1:0] count_increase(
        input logic [pvca_pkg::COUNT_W-1:0] prev,
        input logic [pvca_pkg::COUNT_W-1:0] cnt
    );
        if (prev == '0)
            return pvca_pkg::COUNT_W'(1);
        else if (cnt > prev)
            return cnt - prev;
        else if (cnt < prev)
            return pvca_pkg::WRAP_BASE - prev + cnt;
        return '0;
    endfunction

    task automatic apply_sensor_item(input logic [pvca_pkg::FUNC_W-1:0] func,
                                     input sensor_item_t item);
        logic [pvca_pkg::OUT_DATA_W-1:0] vol;
        vol = '0;
        if (func == pvca_pkg::FUNC_READ)
        begin
            // Last matching slot wins; every match is cleared.
            for (int s = 0; s < pvca_pkg::DEF_SLOTS; s++)
            begin
                if (sensor_id[s] == item.query_id)
                begin
                    vol = volume_acc[s];
                    volume_acc[s] = '0;
                end
            end
            volume_expected.push_back(vol);
        end
        else if (item.packet_type == leave_a || item.packet_type == leave_b)
        begin
            for (int s = 0; s < pvca_pkg::DEF_SLOTS; s++)
            begin
                if (sensor_id[s] == item.sensor_addr)
                begin
                    volume_acc[s] = volume_acc[s]
                                  + count_increase(last_seen[s], item.count_value);
                    last_seen[s] = item.count_value;
                end
            end
        end
    endtask

    task automatic check_volume(input logic [pvca_pkg::OUT_DATA_W-1:0] actual);
        logic [pvca_pkg::OUT_DATA_W-1:0] expected;
        if (volume_expected.size() == 0)
        begin
            $error("volume: unexpected transfer, expected none, actual %0h", actual);
            errors++;
        end
        else
        begin
            expected = volume_expected.pop_front();
            if (expected !== actual)
            begin
                $error("volume mismatch: expected %0h, actual %0h", expected, actual);
                errors++;
            end
        end
    endtask

    task automatic write_setting(input logic [pvca_pkg::CFG_IDX_W-1:0] idx,
                                 input logic [pvca_pkg::CFG_DATA_W-1:0] value);
        if (idx < pvca_pkg::ID_REGS)
            sensor_id[idx] = value[pvca_pkg::ID_W-1:0];
        else if (idx == pvca_pkg::REG_CODE_A)
            leave_a = value[pvca_pkg::TYPE_W-1:0];
        else if (idx == pvca_pkg::REG_CODE_B)
            leave_b = value[pvca_pkg::TYPE_W-1:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < pvca_pkg::ID_REGS; s++)
            begin
                sensor_id[s] = '0;
                last_seen[s] = '0;
                volume_acc[s] = '0;
            end
            leave_a = '0;
            leave_b = '0;
            volume_expected.delete();
        end
        else
        begin
            // Retire results before queuing new reads from the same edge.
            if (m_axis_tvalid && m_axis_tready)
                check_volume(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                apply_sensor_item(s_axis_tuser, s_axis_tdata);
            if (psel && penable && pwrite && pready)
                write_setting(paddr[pvca_pkg::CFG_ADDR_W-1:2], pwdata);
        end
        pending = volume_expected.size();
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives sensor packets and volume reads into the accumulator under several
// slot ID and leave code settings, with random gaps and output stalls; the
// checker predicts every returned volume.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [pvca_pkg::FUNC_W-1:0] FUNC_UPDATE   = 1'b0;
    localparam int                          PHASES        = 5;
    localparam int                          PHASE_ITEMS   = 206;
    localparam int                          SETTLE_CYCLES = 12;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [pvca_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [pvca_pkg::FUNC_W-1:0]     s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [pvca_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [pvca_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [pvca_pkg::CFG_DATA_W-1:0] pwdata = '0;
    logic [pvca_pkg::CFG_DATA_W-1:0] prdata;
    logic                            pready;

    int                              pending;
    int                              errors;
    logic                            steady = 1'b0;

    // Stimulus-side copy of the settings, used to aim addresses and queries.
    logic [pvca_pkg::ID_W-1:0]       id_plan [pvca_pkg::ID_REGS];
    logic [pvca_pkg::TYPE_W-1:0]     code_a_plan;
    logic [pvca_pkg::TYPE_W-1:0]     code_b_plan;
    logic [pvca_pkg::COUNT_W-1:0]    run_count [pvca_pkg::ID_REGS];

    per_sensor_vehicle_count_accumulator uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    vehicle_count_checker volume_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .pending       (pending),
        .errors        (errors)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Result sink: stall at random except during the steady phase.
    always @(posedge clk)
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 33);

    initial
    begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [pvca_pkg::ID_W-1:0] rand_id();
        return pvca_pkg::ID_W'($urandom);
    endfunction

    function automatic logic [pvca_pkg::TYPE_W-1:0] rand_type();
        return pvca_pkg::TYPE_W'($urandom);
    endfunction

    function automatic logic [pvca_pkg::COUNT_W-1:0] rand_count();
        return pvca_pkg::COUNT_W'($urandom);
    endfunction

    // Setup and access cycle; leaves the bus selected for a following write.
    task automatic write_reg(input int idx, input logic [pvca_pkg::CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= pvca_pkg::CFG_ADDR_W'(idx * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk iff pready);
    endtask

    task automatic load_settings();
        for (int i = 0; i < pvca_pkg::ID_REGS; i++)
            write_reg(i, pvca_pkg::CFG_DATA_W'(id_plan[i]));
        write_reg(pvca_pkg::REG_CODE_A, pvca_pkg::CFG_DATA_W'(code_a_plan));
        write_reg(pvca_pkg::REG_CODE_B, pvca_pkg::CFG_DATA_W'(code_b_plan));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Hold valid high across back-to-back items; drop it only for a gap.
    task automatic send_item(input logic [pvca_pkg::FUNC_W-1:0]  func,
                             input logic [pvca_pkg::TYPE_W-1:0]  ptype,
                             input logic [pvca_pkg::ID_W-1:0]    addr,
                             input logic [pvca_pkg::COUNT_W-1:0] cnt,
                             input logic [pvca_pkg::ID_W-1:0]    qid);
        int gap;
        gap = 0;
        while (!steady && $urandom_range(0, 99) < 33)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {qid, cnt, addr, ptype};
        @(posedge clk iff s_axis_tready);
    endtask

    // Drain outstanding reads, then give trailing updates time to finish.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int slot;
        int pick;
        logic [pvca_pkg::FUNC_W-1:0]  func;
        logic [pvca_pkg::TYPE_W-1:0]  ptype;
        logic [pvca_pkg::ID_W-1:0]    addr;
        logic [pvca_pkg::COUNT_W-1:0] cnt;
        logic [pvca_pkg::ID_W-1:0]    qid;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: slots 0 and 2 share an ID, slots 3 and 4 sit at the ID extremes.
        id_plan = '{16'h1234, 16'h00ff, 16'h1234, 16'hffff, 16'h0000, 16'h8001};
        code_a_plan = 8'ha5;
        code_b_plan = 8'h5a;
        load_settings();
        for (int i = 0; i < pvca_pkg::ID_REGS; i++)
            run_count[i] = '0;

        send_item(FUNC_UPDATE, 8'ha5, 16'h1234, 16'h0000, rand_id()); // first count of zero
        send_item(FUNC_UPDATE, 8'h5a, 16'h1234, 16'h0010, rand_id()); // still first count
        send_item(FUNC_UPDATE, 8'ha5, 16'h1234, 16'h0010, rand_id()); // unchanged
        send_item(FUNC_UPDATE, 8'ha5, 16'h1234, 16'h0030, rand_id()); // rise
        send_item(FUNC_UPDATE, 8'ha5, 16'h1234, 16'h0005, rand_id()); // drop
        send_item(FUNC_UPDATE, 8'h00, 16'h1234, 16'hffff, rand_id()); // foreign type
        send_item(pvca_pkg::FUNC_READ, rand_type(), rand_id(), rand_count(), 16'h1234);
        send_item(pvca_pkg::FUNC_READ, rand_type(), rand_id(), rand_count(), 16'h1234);
        send_item(pvca_pkg::FUNC_READ, rand_type(), rand_id(), rand_count(), 16'h4321);
        send_item(FUNC_UPDATE, 8'h5a, 16'hffff, 16'hffff, 16'hffff);
        send_item(FUNC_UPDATE, 8'h5a, 16'hffff, 16'h0000, 16'h0000); // drop by full range
        send_item(FUNC_UPDATE, 8'ha5, 16'hffff, 16'h0001, 16'h0000);
        send_item(FUNC_UPDATE, 8'ha5, 16'hffff, 16'h0000, 16'hffff); // drop by one; volume wraps
        send_item(FUNC_UPDATE, 8'ha5, 16'hffff, 16'hffff, 16'h0000); // treated as a first count
        send_item(pvca_pkg::FUNC_READ, 8'hff, 16'hffff, 16'hffff, 16'hffff);
        send_item(FUNC_UPDATE, 8'h5a, 16'h0000, 16'h8000, 16'hffff);
        send_item(FUNC_UPDATE, 8'h5a, 16'h0000, 16'h8003, 16'h0000);
        send_item(pvca_pkg::FUNC_READ, 8'h00, 16'h0000, 16'h0000, 16'h0000);
        send_item(FUNC_UPDATE, 8'ha5, 16'h8001, 16'h7fff, 16'h8001);
        send_item(pvca_pkg::FUNC_READ, 8'hff, 16'hffff, 16'hffff, 16'h00ff);
        send_item(pvca_pkg::FUNC_READ, 8'h00, 16'h0000, 16'h0000, 16'h8001);
        settle();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            for (int i = 0; i < pvca_pkg::ID_REGS; i++)
            begin
                case (phase)
                    0: id_plan[i] = pvca_pkg::ID_W'($urandom_range(0, 7));
                    1: id_plan[i] = (i == 0) ? rand_id() : id_plan[0];
                    2: id_plan[i] = (i % 2 == 0) ? 16'h0000 : 16'hffff;
                    default: id_plan[i] = rand_id();
                endcase
            end
            code_a_plan = (phase == 2) ? 8'h00 : rand_type();
            code_b_plan = (phase == 2) ? 8'hff : rand_type();
            load_settings();
            if (phase == 1)
                steady <= 1'b1;

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                slot = $urandom_range(0, pvca_pkg::ID_REGS - 1);
                func = ($urandom_range(0, 99) < 25) ? pvca_pkg::FUNC_READ : FUNC_UPDATE;
                pick = $urandom_range(0, 99);
                ptype = (pick < 45) ? code_a_plan :
                        (pick < 88) ? code_b_plan : rand_type();
                addr = ($urandom_range(0, 99) < 82) ? id_plan[slot] : rand_id();
                // Mostly small rises of the running count, with drops and noise.
                pick = $urandom_range(0, 99);
                if (pick < 65)
                    cnt = run_count[slot] + pvca_pkg::COUNT_W'($urandom_range(0, 4));
                else if (pick < 78)
                    cnt = run_count[slot] - pvca_pkg::COUNT_W'($urandom_range(1, 3));
                else if (pick < 84)
                    cnt = '0;
                else
                    cnt = rand_count();
                if (func == FUNC_UPDATE && addr == id_plan[slot])
                    run_count[slot] = cnt;
                qid = ($urandom_range(0, 99) < 85)
                    ? id_plan[$urandom_range(0, pvca_pkg::ID_REGS - 1)]
                    : rand_id();
                send_item(func, ptype, addr, cnt, qid);
            end
            settle();
            steady <= 1'b0;
        end

        if (errors == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
